/* hw/rtl/bfa_pkg.sv */
// Shared types and codes for the best-fit block allocator.
// No dependencies; used by bfa_mem and best_fit_block_allocator.
package bfa_pkg;

  // One heap block record as kept in the block table.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } bfa_entry_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ZERO    = 2'd1,
    STATUS_NOSPACE = 2'd2,
    STATUS_IGNORED = 2'd3
  } bfa_status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } bfa_req_e;

  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } bfa_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } bfa_state_e;

endpackage

/* hw/rtl/bfa_mem.sv */
// Block table storage: one write port, one read port, registered read data.
// Depends on bfa_pkg for the entry record.
module bfa_mem import bfa_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  bfa_entry_t               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output bfa_entry_t               rdata_o
);

  bfa_entry_t mem_q [DEPTH];
  bfa_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/best_fit_block_allocator.sv */
// Best-fit block allocator top level: request FSM, table scan and update.
// Depends on bfa_pkg and bfa_mem.
//
// Usage:
//   Request channel: drive req_type_i, alloc_size_i and free_addr_i and raise
//   start; the request is taken at the clock edge where start is high and busy
//   is low. One result per request comes back on status_o, payload_addr_o and
//   reused_o, valid for exactly one cycle while done_o is high. The receiver
//   cannot hold results off, so the block never waits on the output side.
//   Configuration: cfg_we_i with cfg_idx_i (0 heap base, 1 heap limit) and
//   cfg_wdata_i, one write per cycle, only while busy is low.
//   Flow: a zero-size allocate or a free of address zero answers in the cycle
//   after the request. Any other request scans the block table, one entry per
//   cycle through the single read port of the table memory, unless the table
//   is empty. The next request can be taken in the cycle done_o is high.
//   Reset: block count zero, heap top zero (the reset heap base), heap limit
//   all ones. The table memory is not cleared; only entries below the block
//   count are ever read.
module best_fit_block_allocator import bfa_pkg::*; #(
  parameter int MAX_BLOCKS  = 64,
  parameter int HEADER_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [31:0] alloc_size_i,
  input  logic [31:0] free_addr_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] payload_addr_o,
  output logic        reused_o
);

  localparam int IdxW = $clog2(MAX_BLOCKS);
  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BLOCKS);
  localparam logic [31:0] HdrW = 32'(HEADER_SIZE);

  bfa_state_e state_q, state_d;

  // Architectural state outside the table memory.
  logic [CntW-1:0] count_q;
  logic [31:0]     top_q;
  logic [31:0]     limit_q;

  // Latched request.
  logic            req_free_q;
  logic [31:0]     size_q;
  logic [31:0]     addr_q;

  // Scan pipeline: issue index, then compare in the next cycle.
  logic [CntW-1:0] rd_idx_q;
  logic            cmp_valid_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_start_q;
  logic [31:0]     best_size_q;

  // Result registers.
  logic            done_q;
  bfa_status_e     status_q;
  logic [31:0]     paddr_q;
  logic            reused_q;

  logic            accept;
  logic            trivial;
  logic            issuing;
  bfa_entry_t      rdata;
  logic            hit;
  logic [33:0]     new_top;
  logic            no_room;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  bfa_entry_t      mem_wdata;

  bfa_mem #(
    .DEPTH(MAX_BLOCKS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (issuing),
    .raddr_i(rd_idx_q[IdxW-1:0]),
    .rdata_o(rdata)
  );

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign trivial = (req_type_i == REQ_ALLOC) ? (alloc_size_i == '0) : (free_addr_i == '0);
  assign issuing = (state_q == ST_SCAN) && (rd_idx_q < count_q);

  // Candidate test on the entry just read.
  always_comb begin
    if (req_free_q) begin
      hit = !found_q && ((rdata.start + HdrW) == addr_q);
    end else begin
      hit = rdata.free && (rdata.size >= size_q) && (!found_q || (rdata.size < best_size_q));
    end
  end

  // Append check, never wraps: 34 bits cover top + header + size.
  assign new_top = {2'b00, top_q} + {2'b00, HdrW} + {2'b00, size_q};
  assign no_room = (count_q >= MaxCnt) || (new_top > {2'b00, limit_q});

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = best_idx_q;
    mem_wdata = '{start: best_start_q, size: best_size_q, free: req_free_q};
    case (state_q)
      ST_IDLE: begin
        if (accept && !trivial) begin
          state_d = (count_q == '0) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issuing) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        if (found_q) begin
          mem_we = 1'b1;
        end else if (!req_free_q && !no_room) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[IdxW-1:0];
          mem_wdata = '{start: top_q, size: size_q, free: 1'b0};
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: counts, heap top, limit, scan flags, result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      top_q       <= '0;
      limit_q     <= '1;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      done_q      <= 1'b0;
      cmp_valid_q <= issuing;
      // heap base only matters as the heap top of an empty table
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BASE) begin
          if (count_q == '0) begin
            top_q <= cfg_wdata_i;
          end
        end else begin
          limit_q <= cfg_wdata_i;
        end
      end
      if (accept) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
        done_q   <= trivial;
      end
      if (issuing) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmp_valid_q && hit) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_FIN) begin
        done_q <= 1'b1;
        if (!found_q && !req_free_q && !no_room) begin
          count_q <= count_q + 1'b1;
          top_q   <= new_top[31:0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_free_q <= req_type_i;
      size_q     <= alloc_size_i;
      addr_q     <= free_addr_i;
      status_q   <= (req_type_i == REQ_ALLOC) ? STATUS_ZERO : STATUS_IGNORED;
      paddr_q    <= '0;
      reused_q   <= 1'b0;
    end
    if (issuing) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
    if (cmp_valid_q && hit) begin
      best_idx_q   <= cmp_idx_q;
      best_start_q <= rdata.start;
      best_size_q  <= rdata.size;
    end
    if (state_q == ST_FIN) begin
      paddr_q  <= '0;
      reused_q <= 1'b0;
      if (req_free_q) begin
        status_q <= found_q ? STATUS_OK : STATUS_IGNORED;
      end else if (found_q) begin
        status_q <= STATUS_OK;
        paddr_q  <= best_start_q + HdrW;
        reused_q <= 1'b1;
      end else if (no_room) begin
        status_q <= STATUS_NOSPACE;
      end else begin
        status_q <= STATUS_OK;
        paddr_q  <= top_q + HdrW;
      end
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign payload_addr_o = paddr_q;
  assign reused_o       = reused_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a request is still in flight");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("block count above table depth");

  a_reused_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && reused_o) |-> (status_o == STATUS_OK))
    else $error("reused flag on a refused request");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |-> (payload_addr_o == '0))
    else $error("nonzero address on a refused request");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !cmp_valid_q)
    else $error("update reached before the last table compare");
`endif

endmodule
